FILE: hdl/lfps_pkg.sv
// Shared constants, types and tables for the line follower steering block.
package lfps_pkg;

   // Sensor arrangement and error format
   localparam int SENSOR_COUNT    = 8;
   localparam int ERROR_FRAC_BITS = 8;
   localparam int SCAN_COUNT      = (SENSOR_COUNT < 8) ? SENSOR_COUNT : 8;
   localparam int IDX_W           = $clog2(SCAN_COUNT);
   localparam int CNT_W           = $clog2(SCAN_COUNT + 1);
   localparam int SUM_W           = $clog2(2 * SCAN_COUNT + 1) + 1;
   localparam int MAG_W           = SUM_W - 1;
   localparam int ERR_W           = MAG_W + ERROR_FRAC_BITS;

   // Field widths
   localparam int BITS_W    = 8;
   localparam int BASE_W    = 11;
   localparam int GAIN_W    = 8;
   localparam int RATE_W    = 8;
   localparam int OFFS_W    = 10;
   localparam int SPEED_W   = 13;
   localparam int RATE_FRAC = 8;

   // Configuration port
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam logic [1:0] REG_CRUISE_SPEED = 2'd0;
   localparam logic [1:0] REG_KP_GAIN      = 2'd1;
   localparam logic [1:0] REG_TURN_RATE    = 2'd2;
   localparam logic [1:0] REG_TURN_OFFSET  = 2'd3;

   localparam logic [BASE_W-1:0] CRUISE_SPEED_RST = 11'd0;
   localparam logic [GAIN_W-1:0] KP_GAIN_RST      = 8'd70;
   localparam logic [RATE_W-1:0] TURN_RATE_RST    = 8'd77;
   localparam logic [OFFS_W-1:0] TURN_OFFSET_RST  = 10'd200;

   // Sensor weights, sensor 0 first
   localparam logic signed [2:0] WEIGHT [8] = '{
      -3'sd2, -3'sd2, -3'sd2, -3'sd1, 3'sd1, 3'sd2, 3'sd2, 3'sd2
   };

   typedef enum logic [1:0] {
      HEAD_NONE  = 2'd0,
      HEAD_RIGHT = 2'd1,
      HEAD_LEFT  = 2'd2
   } heading_type;

   typedef struct packed {
      logic [BASE_W-1:0] cruise_speed;
      logic [GAIN_W-1:0] kp_gain;
      logic [RATE_W-1:0] turn_rate_q8;
      logic [OFFS_W-1:0] turn_offset;
   } cfg_type;

endpackage

FILE: hdl/lfps_csr.sv
// Configuration register file behind the APB-style port.
module lfps_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lfps_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [lfps_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [lfps_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready,
   output lfps_pkg::cfg_type            cfg
);
   import lfps_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CRUISE_SPEED: cfg_in.cruise_speed = csr_pwdata[BASE_W-1:0];
            REG_KP_GAIN:      cfg_in.kp_gain      = csr_pwdata[GAIN_W-1:0];
            REG_TURN_RATE:    cfg_in.turn_rate_q8 = csr_pwdata[RATE_W-1:0];
            REG_TURN_OFFSET:  cfg_in.turn_offset  = csr_pwdata[OFFS_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CRUISE_SPEED: csr_prdata = DATA_W'(cfg_ff.cruise_speed);
         REG_KP_GAIN:      csr_prdata = DATA_W'(cfg_ff.kp_gain);
         REG_TURN_RATE:    csr_prdata = DATA_W'(cfg_ff.turn_rate_q8);
         REG_TURN_OFFSET:  csr_prdata = DATA_W'(cfg_ff.turn_offset);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cruise_speed <= CRUISE_SPEED_RST;
         cfg_ff.kp_gain      <= KP_GAIN_RST;
         cfg_ff.turn_rate_q8 <= TURN_RATE_RST;
         cfg_ff.turn_offset  <= TURN_OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/lfps_div.sv
// Restoring divider, one quotient bit per cycle, for the position error.
module lfps_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lfps_pkg::ERR_W-1:0]  dividend,
   input  logic [lfps_pkg::CNT_W-1:0]  divisor,
   output logic                        done,
   output logic [lfps_pkg::ERR_W-1:0]  quotient
);
   import lfps_pkg::*;

   localparam int STEP_W = $clog2(ERR_W + 1);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [ERR_W-1:0]  quo_ff, quo_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;

   assign trial = {rem_ff, quo_ff[ERR_W-1]};
   assign fits  = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(ERR_W);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits the narrow register
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[ERR_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = busy_ff && (step_ff == STEP_W'(1));
   assign quotient = quo_ff;

endmodule

FILE: hdl/line_follow_p_steering.sv
// Top level: sequencer, shared multiplier and result register of the steering block.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    line_bits
//   rsp      out        rsp_valid/stall    left_wheel, right_wheel, turning
//   csr      in/out     APB psel/penable   cruise_speed, kp_gain, turn_rate_q8, turn_offset
//
// A tracking request passes through the accepting cycle, a scan step per sensor, a quotient
// bit per step in the restoring divider, then a multiply step and a result step. A lost-line
// request goes straight to the multiply and result steps; a lost line with no heading yet
// gives no result. req_stall is high from acceptance until the result is loaded.
// The result register takes a new result while the old one is being taken.
// Reset is synchronous and clears the heading, sequencer and result valid.
module line_follow_p_steering (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lfps_pkg::BITS_W-1:0]        req_line_bits,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [lfps_pkg::SPEED_W-1:0] rsp_left_wheel,
   output logic signed [lfps_pkg::SPEED_W-1:0] rsp_right_wheel,
   output logic                               rsp_turning,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lfps_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [lfps_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [lfps_pkg::DATA_W-1:0]        csr_prdata,
   output logic                               csr_pready
);
   import lfps_pkg::*;

   localparam int A_W    = (ERR_W > BASE_W) ? ERR_W : BASE_W;
   localparam int PROD_W = A_W + GAIN_W;
   localparam int CALC_W = PROD_W + 2;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_COUNT - 1);
   localparam logic [ERR_W-1:0] ERR_MAX  = ERR_W'(2 << ERROR_FRAC_BITS);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_DIV  = 5'b00100,
      S_MUL  = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   cfg_type cfg;

   state_type           state_ff, state_in;
   logic [BITS_W-1:0]   bits_ff, bits_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                lost_ff, lost_in;
   heading_type         heading_ff, heading_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SPEED_W-1:0]  left_ff, left_in;
   logic [SPEED_W-1:0]  right_ff, right_in;
   logic                turning_ff, turning_in;

   logic                lost_now;
   logic                out_free;
   logic                load;
   logic [SUM_W-1:0]    sum_neg;
   logic [MAG_W-1:0]    sum_mag;
   logic                div_start;
   logic                div_done;
   logic [ERR_W-1:0]    div_quo;
   logic [ERR_W-1:0]    dividend;
   logic [A_W-1:0]      op_a;
   logic [GAIN_W-1:0]   op_b;
   logic [PROD_W-1:0]   term;
   logic [CALC_W-1:0]   center;
   logic [CALC_W-1:0]   plus_calc;
   logic [CALC_W-1:0]   minus_calc;
   logic                dir_pos;

   function automatic logic [SPEED_W-1:0] sat_speed(input logic [CALC_W-1:0] v);
      logic [CALC_W-SPEED_W:0] top;
      top = v[CALC_W-1:SPEED_W-1];
      if (!v[CALC_W-1] && (top != '0)) begin
         sat_speed = {1'b0, {(SPEED_W-1){1'b1}}};
      end else if (v[CALC_W-1] && (top != '1)) begin
         sat_speed = {1'b1, {(SPEED_W-1){1'b0}}};
      end else begin
         sat_speed = v[SPEED_W-1:0];
      end
   endfunction

   lfps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lfps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (cnt_in),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign lost_now  = &req_line_bits[SCAN_COUNT-1:0];
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = (state_ff == S_EMIT) && out_free;

   // magnitude of the finished sum, scaled to the error fraction
   assign sum_neg  = '0 - sum_in;
   assign sum_mag  = sum_in[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_in[MAG_W-1:0];
   assign dividend = {sum_mag, {ERROR_FRAC_BITS{1'b0}}};

   // shared multiplier operands
   assign op_a = lost_ff ? A_W'(cfg.cruise_speed) : A_W'(div_quo);
   assign op_b = lost_ff ? cfg.turn_rate_q8 : cfg.kp_gain;

   assign term       = lost_ff ? (prod_ff >> RATE_FRAC) : (prod_ff >> ERROR_FRAC_BITS);
   assign center     = lost_ff ? CALC_W'(cfg.turn_offset) : CALC_W'(cfg.cruise_speed);
   assign plus_calc  = center + {2'b00, term};
   assign minus_calc = center - {2'b00, term};
   assign dir_pos    = lost_ff ? (heading_ff == HEAD_RIGHT) : !sum_ff[SUM_W-1];

   always_comb begin
      state_in   = state_ff;
      bits_in    = bits_ff;
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      lost_in    = lost_ff;
      heading_in = heading_ff;
      prod_in    = prod_ff;
      div_start  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               bits_in = req_line_bits;
               idx_in  = '0;
               sum_in  = '0;
               cnt_in  = '0;
               lost_in = lost_now;
               if (!lost_now) begin
                  state_in = S_SCAN;
               end else if (heading_ff == HEAD_RIGHT || heading_ff == HEAD_LEFT) begin
                  state_in = S_MUL;
               end
               // drop a lost-line request while no heading is known
            end
         end
         S_SCAN: begin
            if (!bits_ff[idx_ff]) begin
               sum_in = sum_ff + {{(SUM_W-3){WEIGHT[idx_ff][2]}}, WEIGHT[idx_ff]};
               cnt_in = cnt_ff + CNT_W'(1);
            end
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = PROD_W'(op_a) * PROD_W'(op_b);
            if (!lost_ff && (div_quo != '0)) begin
               heading_in = sum_ff[SUM_W-1] ? HEAD_LEFT : HEAD_RIGHT;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      left_in      = left_ff;
      right_in     = right_ff;
      turning_in   = turning_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         left_in      = sat_speed(dir_pos ? plus_calc : minus_calc);
         right_in     = sat_speed(dir_pos ? minus_calc : plus_calc);
         turning_in   = lost_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         heading_ff   <= HEAD_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heading_ff   <= heading_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bits_ff    <= bits_in;
      idx_ff     <= idx_in;
      sum_ff     <= sum_in;
      cnt_ff     <= cnt_in;
      lost_ff    <= lost_in;
      prod_ff    <= prod_in;
      left_ff    <= left_in;
      right_ff   <= right_in;
      turning_ff <= turning_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_wheel  = left_ff;
   assign rsp_right_wheel = right_ff;
   assign rsp_turning     = turning_ff;

   a_turn_needs_heading: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && turning_ff) |-> (heading_ff != HEAD_NONE))
      else $error("spin turn result without a known heading");

   a_lost_unknown_drops: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && lost_now && heading_ff == HEAD_NONE)
      |=> (state_ff == S_IDLE))
      else $error("lost-line request with no heading was not dropped");

   a_load_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result loaded outside the result cycle");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff != '0))
      else $error("division by a zero sensor count");

   a_error_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && !lost_ff) |-> (div_quo <= ERR_MAX))
      else $error("position error beyond the largest weight");

endmodule
